// ===== src/bpa_pkg.sv =====
package bpa_pkg;

   // Width of the address arithmetic: a 32-bit base, plus an offset of at most
   // 22 bits, plus an alignment term, with headroom for the carry.
   localparam int CALC_W = 35;

   localparam logic [31:0] BASE_ADDR_RESET = 32'h0010_0000;
   localparam logic [21:0] DEF_ALIGN_M1    = 22'd15;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REWIND = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ALIGN_CHK,
      ST_BOUND_CHK,
      ST_WALK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [21:0] size_bytes;
      logic [21:0] align_bytes;
      logic [31:0] max_phys_addr;
      logic [31:0] free_addr;
      logic [21:0] checkpoint_offset;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] buffer_addr;
      logic [21:0] used_bytes;
      logic [5:0]  live_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [21:0] size;
   } rec_type;

endpackage

// ===== src/bpa_rec_mem.sv =====
module bpa_rec_mem #(
   parameter int RECORDS = 32,
   parameter int IDX_W   = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  bpa_pkg::rec_type     wr_data,
   input  logic [IDX_W-1:0]     rd_idx,
   output bpa_pkg::rec_type     rd_data
);

   bpa_pkg::rec_type rec_mem_ff [RECORDS];
   bpa_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= rec_mem_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bpa_engine.sv =====
module bpa_engine #(
   parameter int POOL_BYTES = 2097152,
   parameter int RECORDS    = 32,
   parameter int IDX_W      = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          base_addr,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bpa_pkg::req_type     req_data,
   output logic                 res_valid,
   output bpa_pkg::rsp_type     res_data,
   input  logic                 res_take,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_idx,
   output bpa_pkg::rec_type     mem_wr_data,
   output logic [IDX_W-1:0]     mem_rd_idx,
   input  bpa_pkg::rec_type     mem_rd_data
);

   localparam int CW    = bpa_pkg::CALC_W;
   localparam int CNT_W = $clog2(RECORDS + 1);
   localparam int OFF_W = $clog2(POOL_BYTES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RECORDS - 1);
   localparam logic [CNT_W-1:0] REC_CNT   = CNT_W'(RECORDS);
   localparam logic [CW-1:0]    POOL_SIZE = CW'(POOL_BYTES);

   bpa_pkg::state_type state_ff, state_in;
   bpa_pkg::req_type   req_ff, req_in;
   bpa_pkg::rsp_type   res_ff, res_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RECORDS-1:0] valid_ff, valid_in;
   logic [CW-1:0]      work_a_ff, work_a_in;
   logic [CW-1:0]      work_b_ff, work_b_in;
   logic [CW-1:0]      work_c_ff, work_c_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;

   logic [21:0]        align_m1;
   logic [CW-1:0]      align_sum;
   logic               finish;
   logic               fin_ok;
   logic [31:0]        fin_addr;
   logic               slot_valid;
   logic               rec_hit;
   logic               tail_hit;
   logic               bound_fail;
   logic [OFF_W+21:0]  used_ext;
   logic [CNT_W+5:0]   cnt_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_IDLE;
         off_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         off_ff   <= off_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      work_a_ff   <= work_a_in;
      work_b_ff   <= work_b_in;
      work_c_ff   <= work_c_in;
      pend_idx_ff <= pend_idx_in;
   end

   assign mem_rd_idx = issue_ff[IDX_W-1:0];
   assign slot_valid = valid_ff[pend_idx_ff];
   assign rec_hit    = (mem_rd_data.addr == req_ff.free_addr) &&
                       (mem_rd_data.size == req_ff.size_bytes);
   // Freed block sits at the top of the pool: offset may drop back
   assign tail_hit   = (work_a_ff == work_b_ff) &&
                       (CW'(req_ff.size_bytes) <= CW'(off_ff));
   assign bound_fail = (req_ff.size_bytes == 22'd0) || (work_c_ff > POOL_SIZE) ||
                       (|work_b_ff[CW-1:32]) ||
                       ((req_ff.max_phys_addr != 32'd0) &&
                        (work_b_ff > CW'(req_ff.max_phys_addr)));
   assign align_m1   = (req_ff.align_bytes == 22'd0) ? bpa_pkg::DEF_ALIGN_M1 :
                       req_ff.align_bytes - 22'd1;
   assign align_sum  = CW'(base_addr) + CW'(off_ff) + CW'(align_m1);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      res_in      = res_ff;
      off_in      = off_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      work_a_in   = work_a_ff;
      work_b_in   = work_b_ff;
      work_c_in   = work_c_ff;
      issue_in    = '0;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      finish      = 1'b0;
      fin_ok      = 1'b1;
      fin_addr    = 32'd0;
      mem_wr_en   = 1'b0;
      mem_wr_idx  = pend_idx_ff;
      mem_wr_data = '{addr: work_a_ff[31:0], size: req_ff.size_bytes};

      case (state_ff)
         bpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = bpa_pkg::ST_PREP;
            end
         end

         bpa_pkg::ST_PREP: begin
            case (req_ff.op)
               bpa_pkg::OP_ALLOC: begin
                  work_a_in = align_sum & ~CW'(align_m1);
                  state_in  = bpa_pkg::ST_ALIGN_CHK;
               end
               bpa_pkg::OP_FREE: begin
                  work_a_in = CW'(base_addr) + CW'(off_ff);
                  work_b_in = CW'(req_ff.free_addr) + CW'(req_ff.size_bytes);
                  state_in  = bpa_pkg::ST_WALK;
               end
               bpa_pkg::OP_REWIND: begin
                  if (CW'(req_ff.checkpoint_offset) > CW'(off_ff)) begin
                     finish = 1'b1;
                  end else begin
                     off_in    = OFF_W'(req_ff.checkpoint_offset);
                     work_a_in = CW'(base_addr) + CW'(req_ff.checkpoint_offset);
                     state_in  = bpa_pkg::ST_WALK;
                  end
               end
               default: begin
                  off_in   = '0;
                  cnt_in   = '0;
                  valid_in = '0;
                  finish   = 1'b1;
               end
            endcase
         end

         bpa_pkg::ST_ALIGN_CHK: begin
            // last byte address and end offset, both from the aligned start
            work_b_in = work_a_ff + CW'(req_ff.size_bytes) - CW'(1);
            work_c_in = work_a_ff - CW'(base_addr) + CW'(req_ff.size_bytes);
            state_in  = bpa_pkg::ST_BOUND_CHK;
         end

         bpa_pkg::ST_BOUND_CHK: begin
            if (bound_fail) begin
               finish = 1'b1;
               fin_ok = 1'b0;
            end else begin
               off_in   = work_c_ff[OFF_W-1:0];
               state_in = bpa_pkg::ST_WALK;
            end
         end

         bpa_pkg::ST_WALK: begin
            // one read issued per cycle, tested in the cycle after
            pend_in     = (issue_ff < REC_CNT);
            pend_idx_in = issue_ff[IDX_W-1:0];
            issue_in    = pend_in ? issue_ff + CNT_W'(1) : issue_ff;
            if (pend_ff) begin
               case (req_ff.op)
                  bpa_pkg::OP_ALLOC: begin
                     fin_addr = work_a_ff[31:0];
                     if (!slot_valid) begin
                        mem_wr_en             = 1'b1;
                        valid_in[pend_idx_ff] = 1'b1;
                        cnt_in                = cnt_ff + CNT_W'(1);
                        finish                = 1'b1;
                     end else if (pend_idx_ff == LAST_IDX) begin
                        finish = 1'b1;
                     end
                  end
                  bpa_pkg::OP_FREE: begin
                     if (slot_valid && rec_hit) begin
                        valid_in[pend_idx_ff] = 1'b0;
                        cnt_in                = cnt_ff - CNT_W'(1);
                        if (tail_hit) begin
                           off_in = OFF_W'(CW'(off_ff) - CW'(req_ff.size_bytes));
                        end
                        finish = 1'b1;
                     end else if (pend_idx_ff == LAST_IDX) begin
                        finish = 1'b1;
                        fin_ok = 1'b0;
                     end
                  end
                  default: begin
                     if (slot_valid && (CW'(mem_rd_data.addr) >= work_a_ff)) begin
                        valid_in[pend_idx_ff] = 1'b0;
                        cnt_in                = cnt_ff - CNT_W'(1);
                     end
                     if (pend_idx_ff == LAST_IDX) begin
                        finish = 1'b1;
                     end
                  end
               endcase
            end
         end

         bpa_pkg::ST_RESULT: begin
            if (res_take) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bpa_pkg::ST_IDLE;
         end
      endcase

      used_ext = {22'd0, off_in};
      cnt_ext  = {6'd0, cnt_in};
      if (finish) begin
         res_in.ok          = fin_ok;
         res_in.buffer_addr = fin_ok ? fin_addr : 32'd0;
         res_in.used_bytes  = used_ext[21:0];
         res_in.live_count  = cnt_ext[5:0];
         state_in           = bpa_pkg::ST_RESULT;
      end
   end

   assign req_stall = (state_ff != bpa_pkg::ST_IDLE);
   assign res_valid = (state_ff == bpa_pkg::ST_RESULT);
   assign res_data  = res_ff;

endmodule

// ===== src/bump_pool_allocator.sv =====
// Channel   Direction  Ports                           Moves
// request   in         req_valid, req_stall, req_data  one operation (bpa_pkg::req_type)
// response  out        rsp_valid, rsp_stall, rsp_data  one result (bpa_pkg::rsp_type)
// csr       in         csr_wr_en, csr_wr_data          pool base address
//
// One request is worked at a time. Alloc, free and rewind walk the record
// table one entry per cycle through the single read port of the record memory;
// clear does not walk it.
// Reset is synchronous; record valid bits are flip-flops cleared at once, so no
// clearing pass follows reset. A stalled response sits in the output register
// while the next request is already accepted and worked on.
module bump_pool_allocator #(
   parameter int POOL_BYTES = 2097152,
   parameter int RECORDS    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bpa_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bpa_pkg::rsp_type     rsp_data,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);

   localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;

   logic [31:0]          base_addr_ff;
   logic                 rsp_valid_ff;
   bpa_pkg::rsp_type     rsp_data_ff;

   logic                 res_valid;
   bpa_pkg::rsp_type     res_data;
   logic                 res_take;

   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_idx;
   bpa_pkg::rec_type     mem_wr_data;
   logic [IDX_W-1:0]     mem_rd_idx;
   bpa_pkg::rec_type     mem_rd_data;

   // Pool base register; the block is to be idle when software writes it (unenforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         base_addr_ff <= bpa_pkg::BASE_ADDR_RESET;
      end else if (csr_wr_en) begin
         base_addr_ff <= csr_wr_data;
      end
   end

   // Output register: a finished result moves in when the register is empty
   // or its current contents are being taken this cycle.
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Allocation records: address and size per slot.
   bpa_rec_mem #(
      .RECORDS (RECORDS),
      .IDX_W   (IDX_W)
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_idx  (mem_wr_idx),
      .wr_data (mem_wr_data),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rd_data)
   );

   // Sequencer: alignment and bound checks on alloc, then the walk; clear skips both.
   bpa_engine #(
      .POOL_BYTES (POOL_BYTES),
      .RECORDS    (RECORDS),
      .IDX_W      (IDX_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .base_addr   (base_addr_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_take    (res_take),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_idx  (mem_wr_idx),
      .mem_wr_data (mem_wr_data),
      .mem_rd_idx  (mem_rd_idx),
      .mem_rd_data (mem_rd_data)
   );

endmodule

// ===== src/bpa_checker.sv =====
module bpa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input bpa_pkg::rsp_type     rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // once a request is taken, no other is taken until it is worked
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // a response only appears out of a request in work
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in work");

   // an address is only returned by a successful alloc
   a_addr_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.buffer_addr != 32'd0) |-> rsp_data.ok)
      else $error("buffer address returned on failure");

endmodule

bind bump_pool_allocator bpa_checker u_bpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
